### src/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg: shared types and codes for the stack machine execute unit
// Operation codes, result codes and the front-to-back request record.
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int FUNC_W  = 5;
    localparam int CELL_W  = 64;
    localparam int CELL_B  = 8;

    localparam logic [4:0] F_PUSH = 5'd0,  F_ADD  = 5'd1,  F_SUB  = 5'd2,  F_MUL  = 5'd3;
    localparam logic [4:0] F_DIV  = 5'd4,  F_PRT  = 5'd5,  F_DUP  = 5'd6,  F_SWAP = 5'd7;
    localparam logic [4:0] F_ROT  = 5'd8,  F_OVER = 5'd9,  F_DROP = 5'd10, F_LT   = 5'd11;
    localparam logic [4:0] F_LE   = 5'd12, F_NE   = 5'd13, F_EQ   = 5'd14, F_GT   = 5'd15;
    localparam logic [4:0] F_GE   = 5'd16, F_AND  = 5'd17, F_OR   = 5'd18, F_XOR  = 5'd19;
    localparam logic [4:0] F_INV  = 5'd20, F_EMIT = 5'd21, F_STO  = 5'd22, F_FET  = 5'd23;
    localparam logic [4:0] F_HERE = 5'd24, F_ALLT = 5'd25, F_ALGN = 5'd26, F_ALGD = 5'd27;

    localparam logic [1:0] ST_PUSHED = 2'd0, ST_DONE = 2'd1, ST_ERROR = 2'd2;

    localparam logic [2:0] E_NONE = 3'd0, E_UNDER = 3'd1, E_OVER = 3'd2, E_DIVZ = 3'd3;
    localparam logic [2:0] E_STO  = 3'd4, E_FET   = 3'd5, E_ALLB = 3'd6, E_FULL = 3'd7;

    // classified request from front to back
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CELL_W-1:0] value;
        logic [1:0]        need;
        logic              grow;
    } smeu_req_t;

    // result record
    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        error_code;
        logic              print_valid;
        logic              print_is_char;
        logic [CELL_W-1:0] print_value;
        logic [6:0]        stack_depth;
        logic [CELL_W-1:0] top_value;
    } smeu_res_t;

endpackage

### src/smeu_front.sv
// ----------------------------------------------------------------------------
// smeu_front: input stage and request queue
// Accepts requests, works out operand need and growth, queues two deep.
// ----------------------------------------------------------------------------
module smeu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [4:0]           in_func,
    input  logic [63:0]          in_value,
    output logic                 q_valid,
    input  logic                 q_pop,
    output smeu_pkg::smeu_req_t  q_req
);
    import smeu_pkg::*;

    smeu_req_t  slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    smeu_req_t  cls;
    logic       push;

    // classify operand need and stack growth
    always_comb begin
        cls.func  = in_func;
        cls.value = in_value;
        cls.need  = 2'd0;
        cls.grow  = 1'b0;
        if (in_func == F_ROT) cls.need = 2'd3;
        else if ((in_func >= F_ADD && in_func <= F_DIV) || in_func == F_SWAP ||
                 in_func == F_OVER || (in_func >= F_LT && in_func <= F_XOR) ||
                 in_func == F_STO) cls.need = 2'd2;
        else if (in_func == F_PRT || in_func == F_DUP || in_func == F_DROP ||
                 in_func == F_INV || in_func == F_EMIT || in_func == F_FET ||
                 in_func == F_ALLT) cls.need = 2'd1;
        cls.grow = (in_func == F_PUSH || in_func == F_DUP || in_func == F_OVER ||
                    in_func == F_HERE || in_func == F_ALGD);
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = slot_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !(q_pop && q_valid)) cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop && q_valid) cnt_next = cnt_reg - 2'd1;
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (q_pop && q_valid) rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_reg] <= cls;
    end
endmodule

### src/smeu_div.sv
// ----------------------------------------------------------------------------
// smeu_div: iterative signed divider
// Restoring division, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module smeu_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] rem_reg, quo_reg, dvs_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg, busy_reg;
    logic [64:0] trial;
    logic [63:0] rem_sh;

    assign rem_sh   = {rem_reg[62:0], quo_reg[63]};
    assign trial    = {1'b0, rem_sh} - {1'b0, dvs_reg};
    assign done     = busy_reg && (cnt_reg == 7'd0);
    assign quotient = neg_reg ? (64'd0 - quo_reg) : quo_reg;

    // one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'd64;
        end else if (busy_reg && cnt_reg != 7'd0) begin
            cnt_reg <= cnt_reg - 7'd1;
        end else begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend[63] ? (64'd0 - dividend) : dividend;
            dvs_reg <= divisor[63] ? (64'd0 - divisor) : divisor;
            neg_reg <= dividend[63] ^ divisor[63];
        end else if (busy_reg && cnt_reg != 7'd0) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end
endmodule

### src/smeu_back.sv
// ----------------------------------------------------------------------------
// smeu_back: execute sequencer
// Carries out one request at a time on the stack and data space memories.
// ----------------------------------------------------------------------------
module smeu_back #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_BYTES  = 8192
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  smeu_pkg::smeu_req_t  q_req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output smeu_pkg::smeu_res_t  res
);
    import smeu_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int BAW = $clog2(DATA_BYTES);
    localparam int HW  = $clog2(DATA_BYTES + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_RD1 = 4'd1, S_RD2 = 4'd2, S_RD3 = 4'd3,
                           S_EXE = 4'd4, S_MUL = 4'd5, S_DIV = 4'd6, S_MEM = 4'd7,
                           S_FILL = 4'd8, S_WB = 4'd9, S_TOP = 4'd10, S_OUT = 4'd11;

    logic [63:0] stk_mem [STACK_DEPTH];
    logic [7:0]  dsp_mem [DATA_BYTES];

    logic [3:0]    st_reg;
    logic [DW-1:0] dep_reg;
    logic [HW-1:0] here_reg;
    smeu_req_t     cur_reg;
    logic [63:0]   a_reg, b_reg, c_reg;
    logic [1:0]    nr_reg, nw_reg;
    logic [63:0]   w0_reg, w1_reg, w2_reg;
    logic [3:0]    bi_reg;
    logic [HW-1:0] fend_reg;
    logic [2:0]    err_reg;
    logic          pv_reg, pc_reg;
    logic [63:0]   pval_reg;
    logic          ovalid_reg;
    smeu_res_t     out_reg;

    // stack read port, registered data
    logic [SAW-1:0] srd_addr;
    logic [63:0]    srd_q;
    logic           s_we;
    logic [SAW-1:0] s_waddr;
    logic [63:0]    s_wdata;
    always_ff @(posedge aclk) begin
        if (s_we) stk_mem[s_waddr] <= s_wdata;
        srd_q <= stk_mem[srd_addr];
    end

    // data space, byte wide, registered read
    logic [BAW-1:0] d_raddr, d_waddr;
    logic [7:0]     d_q, d_wdata;
    logic           d_we;
    always_ff @(posedge aclk) begin
        if (d_we) dsp_mem[d_waddr] <= d_wdata;
        d_q <= dsp_mem[d_raddr];
    end

    // divider and multiplier partial products
    logic        div_start, div_done;
    logic [63:0] div_q;
    smeu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(a_reg), .divisor(b_reg), .done(div_done), .quotient(div_q)
    );
    logic [1:0]  mstep_reg;
    logic [63:0] mp_reg;
    logic [31:0] mx, my;
    logic [63:0] mprod;
    always_comb begin
        unique case (mstep_reg)
            2'd0:    begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            2'd1:    begin mx = a_reg[63:32]; my = b_reg[31:0];  end
            default: begin mx = a_reg[31:0];  my = b_reg[63:32]; end
        endcase
        mprod = {32'd0, mx} * {32'd0, my};
    end

    // address and bound checks
    logic        inrange;
    logic [63:0] here64, al64, nega;
    assign here64  = 64'(here_reg);
    assign al64    = 64'((here_reg + HW'(7)) & ~HW'(7));
    assign inrange = (a_reg <= here64) && ((here64 - a_reg) >= 64'(CELL_B));
    assign nega    = 64'd0 - a_reg;

    // top of stack is read while the result is built and held
    logic [DW-1:0] rd_idx;
    assign rd_idx   = dep_reg - DW'(nr_reg) - DW'(1);
    assign srd_addr = (st_reg == S_TOP || st_reg == S_OUT) ? SAW'(dep_reg - DW'(1)) :
                      SAW'(rd_idx);
    logic [DW-1:0] base;
    assign base    = dep_reg - DW'(cur_reg.need);
    assign d_raddr = BAW'(a_reg[BAW-1:0] + BAW'(bi_reg[2:0]));

    logic cmp_lt, cmp_gt, cmp_r;
    assign cmp_lt = $signed(a_reg) < $signed(b_reg);
    assign cmp_gt = $signed(b_reg) < $signed(a_reg);
    always_comb begin
        unique case (cur_reg.func)
            F_LT:    cmp_r = cmp_lt;
            F_LE:    cmp_r = !cmp_gt;
            F_NE:    cmp_r = a_reg != b_reg;
            F_EQ:    cmp_r = a_reg == b_reg;
            F_GT:    cmp_r = cmp_gt;
            default: cmp_r = !cmp_lt;
        endcase
    end

    assign q_pop     = (st_reg == S_IDLE) && q_valid;
    assign res_valid = ovalid_reg;
    assign res       = out_reg;
    assign div_start = (st_reg == S_EXE) && cur_reg.func == F_DIV && b_reg != 64'd0;

    // write ports; a store writes only once the whole cell is known in range,
    // and the fill writes nothing on its final check cycle
    always_comb begin
        s_we    = (st_reg == S_WB) && (nw_reg != 2'd0) && (err_reg == E_NONE);
        s_waddr = SAW'(base + DW'(bi_reg[1:0]));
        s_wdata = (bi_reg[1:0] == 2'd0) ? w0_reg : (bi_reg[1:0] == 2'd1) ? w1_reg : w2_reg;
        d_we    = 1'b0;
        d_waddr = BAW'(a_reg[BAW-1:0] + BAW'(bi_reg[2:0]));
        d_wdata = b_reg[8*bi_reg[2:0] +: 8];
        if (st_reg == S_MEM && cur_reg.func == F_STO && inrange) d_we = 1'b1;
        if (st_reg == S_FILL) begin
            d_we    = (here_reg != fend_reg);
            d_waddr = BAW'(here_reg);
            d_wdata = 8'd0;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_IDLE;
            dep_reg    <= '0;
            here_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (ovalid_reg && res_ready) ovalid_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (q_valid) begin
                    cur_reg  <= q_req;
                    nr_reg   <= '0;
                    nw_reg   <= '0;
                    bi_reg   <= '0;
                    err_reg  <= E_NONE;
                    pv_reg   <= 1'b0;
                    pc_reg   <= 1'b0;
                    pval_reg <= '0;
                    if (dep_reg < DW'(q_req.need)) begin
                        err_reg <= E_UNDER;
                        st_reg  <= S_TOP;
                    end else if (q_req.grow && dep_reg >= DW'(STACK_DEPTH)) begin
                        err_reg <= E_OVER;
                        st_reg  <= S_TOP;
                    end else if (q_req.need != 2'd0) begin
                        nr_reg <= q_req.need - 2'd1;
                        st_reg <= S_RD1;
                    end else begin
                        st_reg <= S_EXE;
                    end
                end
                // operand reads, deepest first lands in a
                S_RD1: st_reg <= S_RD2;
                S_RD2: begin
                    if (nr_reg == 2'd0) begin
                        a_reg <= (cur_reg.need == 2'd3) ? b_reg :
                                 (cur_reg.need == 2'd2) ? c_reg : srd_q;
                        b_reg <= (cur_reg.need == 2'd3) ? c_reg : srd_q;
                        c_reg <= srd_q;
                        st_reg <= S_EXE;
                    end else begin
                        c_reg  <= srd_q;
                        b_reg  <= c_reg;
                        a_reg  <= b_reg;
                        nr_reg <= nr_reg - 2'd1;
                        st_reg <= S_RD3;
                    end
                end
                S_RD3: st_reg <= S_RD2;
                S_EXE: begin
                    nw_reg <= 2'd1;
                    st_reg <= S_WB;
                    unique case (cur_reg.func)
                        F_PUSH: w0_reg <= cur_reg.value;
                        F_ADD:  w0_reg <= a_reg + b_reg;
                        F_SUB:  w0_reg <= a_reg - b_reg;
                        F_MUL:  begin mstep_reg <= 2'd0; st_reg <= S_MUL; end
                        F_DIV:  if (b_reg == 64'd0) begin
                                    err_reg <= E_DIVZ; st_reg <= S_TOP;
                                end else st_reg <= S_DIV;
                        F_PRT:  begin nw_reg <= 2'd0; pv_reg <= 1'b1; pval_reg <= b_reg; end
                        F_EMIT: begin
                            nw_reg <= 2'd0; pv_reg <= 1'b1; pc_reg <= 1'b1;
                            pval_reg <= {56'd0, b_reg[7:0]};
                        end
                        F_DUP: begin nw_reg <= 2'd2; w0_reg <= a_reg; w1_reg <= b_reg; end
                        // rewrite both operands, then the copy of the lower one on top
                        F_OVER: begin
                            nw_reg <= 2'd3; w0_reg <= a_reg; w1_reg <= b_reg;
                            w2_reg <= a_reg;
                        end
                        F_SWAP: begin nw_reg <= 2'd2; w0_reg <= b_reg; w1_reg <= a_reg; end
                        F_ROT: begin
                            nw_reg <= 2'd3; w0_reg <= b_reg; w1_reg <= c_reg; w2_reg <= a_reg;
                        end
                        F_DROP: nw_reg <= 2'd0;
                        F_LT, F_LE, F_NE, F_EQ, F_GT, F_GE: w0_reg <= {64{cmp_r}};
                        F_AND:  w0_reg <= a_reg & b_reg;
                        F_OR:   w0_reg <= a_reg | b_reg;
                        F_XOR:  w0_reg <= a_reg ^ b_reg;
                        F_INV:  w0_reg <= ~b_reg;
                        F_STO: begin
                            // a is the address (top), b the data below it
                            a_reg <= b_reg; b_reg <= a_reg; nw_reg <= 2'd0;
                            st_reg <= S_MEM;
                        end
                        F_FET: begin a_reg <= b_reg; st_reg <= S_MEM; end
                        F_HERE: w0_reg <= here64;
                        F_ALGD: w0_reg <= al64;
                        F_ALLT: begin a_reg <= b_reg; nw_reg <= 2'd0; st_reg <= S_MEM; end
                        F_ALGN: begin
                            nw_reg <= 2'd0;
                            if (al64 > 64'(DATA_BYTES)) begin
                                err_reg <= E_FULL; st_reg <= S_TOP;
                            end else begin
                                fend_reg <= HW'(al64); st_reg <= S_FILL;
                            end
                        end
                        default: begin nw_reg <= 2'd0; st_reg <= S_TOP; end
                    endcase
                end
                S_MUL: begin
                    mstep_reg <= mstep_reg + 2'd1;
                    unique case (mstep_reg)
                        2'd0: mp_reg <= mprod;
                        2'd1: mp_reg <= mp_reg + {mprod[31:0], 32'd0};
                        2'd2: mp_reg <= mp_reg + {mprod[31:0], 32'd0};
                        default: begin w0_reg <= mp_reg; st_reg <= S_WB; end
                    endcase
                end
                S_DIV: if (div_done) begin w0_reg <= div_q; st_reg <= S_WB; end
                S_MEM: begin
                    if (cur_reg.func == F_ALLT) begin
                        if (a_reg[63]) begin
                            if (nega > here64) begin
                                here_reg <= '0; err_reg <= E_ALLB;
                            end else here_reg <= here_reg - HW'(nega);
                            st_reg <= S_WB;
                        end else if (a_reg > 64'(DATA_BYTES) - here64) begin
                            err_reg <= E_FULL; st_reg <= S_WB;
                        end else begin
                            fend_reg <= here_reg + HW'(a_reg); st_reg <= S_FILL;
                        end
                    end else if (!inrange) begin
                        err_reg <= (cur_reg.func == F_STO) ? E_STO : E_FET;
                        st_reg  <= S_WB;
                    end else if (cur_reg.func == F_STO) begin
                        bi_reg <= bi_reg + 4'd1;
                        if (bi_reg == 4'd7) begin bi_reg <= '0; st_reg <= S_WB; end
                    end else begin
                        // fetch: byte bi issued, previous byte arrives
                        bi_reg <= bi_reg + 4'd1;
                        if (bi_reg != 4'd0) w0_reg <= {d_q, w0_reg[63:8]};
                        if (bi_reg == 4'd8) begin
                            bi_reg <= '0; st_reg <= S_WB;
                        end
                    end
                end
                S_FILL: begin
                    if (here_reg == fend_reg) st_reg <= S_WB;
                    else here_reg <= here_reg + HW'(1);
                end
                S_WB: begin
                    if (err_reg != E_NONE) begin
                        st_reg <= S_TOP;
                    end else if (nw_reg == 2'd0) begin
                        dep_reg <= base;
                        st_reg  <= S_TOP;
                    end else if (bi_reg[1:0] + 2'd1 >= nw_reg) begin
                        dep_reg <= base + DW'(nw_reg);
                        bi_reg  <= '0;
                        st_reg  <= S_TOP;
                    end else begin
                        bi_reg <= bi_reg + 4'd1;
                    end
                end
                S_TOP: begin
                    if (err_reg != E_NONE) dep_reg <= '0;
                    st_reg <= S_OUT;
                end
                S_OUT: if (!ovalid_reg || res_ready) begin
                    ovalid_reg <= 1'b1;
                    out_reg.status <= (err_reg != E_NONE) ? ST_ERROR :
                                      (cur_reg.func == F_PUSH) ? ST_PUSHED : ST_DONE;
                    out_reg.error_code    <= err_reg;
                    out_reg.print_valid   <= pv_reg && err_reg == E_NONE;
                    out_reg.print_is_char <= pc_reg && err_reg == E_NONE;
                    out_reg.print_value   <= (err_reg == E_NONE) ? pval_reg : '0;
                    out_reg.stack_depth   <= 7'(dep_reg);
                    out_reg.top_value     <= (dep_reg == '0) ? '0 : srd_q;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### src/stack_machine_execute_unit_core.sv
// Stack underflow and overflow are found at decode, before any operand is read.
// Throughput: one request at a time in the execute sequencer; the next starts once the
// result is registered. A two-entry queue and the output register decouple the sides.
// Reset: aresetn synchronous, active low; clears stack depth, here pointer, result valid.
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core: Forth primitive execute unit
// Front queue, back execute sequencer on stack and data-space memories.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_core #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_BYTES  = 8192
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // func[4:0], value[68:5], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // status, error_code, print_valid, print_is_char,
                                    // print_value, stack_depth, top_value, zero pad
);
    import smeu_pkg::*;

    logic      q_valid, q_pop;
    smeu_req_t q_req;
    smeu_res_t res;

    smeu_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_func(s_tdata[4:0]), .in_value(s_tdata[68:5]),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    smeu_back #(.STACK_DEPTH(STACK_DEPTH), .DATA_BYTES(DATA_BYTES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {2'd0, res.top_value, res.stack_depth, res.print_value,
                      res.print_is_char, res.print_valid, res.error_code, res.status};
endmodule

### test/stack_machine_execute_unit_checker.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_checker: result predictor and scoreboard
// Watches both stream channels of the execute unit, keeps its own copy of
// the data stack and data space, works out the result of every accepted
// request and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_checker #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_BYTES  = 8192
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,   // func[4:0], value[68:5], zero pad
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,   // status, error_code, print_valid, print_is_char,
                                    // print_value, stack_depth, top_value, zero pad
    output int           fail_count,
    output int           pending
);
    import smeu_pkg::*;

    localparam int EXP_SLOTS = 16;

    logic [63:0] stk [STACK_DEPTH];
    int          depth;
    logic [7:0]  mem [DATA_BYTES];
    int          here_ptr;

    // expected results, written on request accept, read on result accept
    smeu_res_t   exp_mem [EXP_SLOTS];
    int          exp_wr;
    int          exp_rd;

    function automatic logic [63:0] pop_cell();
        depth--;
        return stk[depth];
    endfunction

    function automatic void push_cell(logic [63:0] v);
        stk[depth] = v;
        depth++;
    endfunction

    function automatic int next_aligned();
        return (here_ptr % CELL_B) != 0 ? here_ptr + (CELL_B - here_ptr % CELL_B) : here_ptr;
    endfunction

    // whole cell must lie below here
    function automatic bit cell_ok(logic [63:0] a);
        return a <= 64'(here_ptr) && 64'(here_ptr) - a >= 64'(CELL_B);
    endfunction

    // truncating signed divide; most negative / -1 wraps
    function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic smeu_res_t execute(logic [4:0] f, logic [63:0] lit);
        smeu_res_t   r;
        int          need;
        bit          grow;
        logic [63:0] a, b, c, m;
        int          n;
        r = '0;
        r.status = ST_DONE;
        r.error_code = E_NONE;
        case (f)
            F_ADD, F_SUB, F_MUL, F_DIV, F_SWAP, F_OVER, F_STO,
            F_LT, F_LE, F_NE, F_EQ, F_GT, F_GE, F_AND, F_OR, F_XOR: need = 2;
            F_PRT, F_DUP, F_DROP, F_INV, F_EMIT, F_FET, F_ALLT:      need = 1;
            F_ROT:                                                  need = 3;
            default:                                                need = 0;
        endcase
        grow = f inside {F_PUSH, F_DUP, F_OVER, F_HERE, F_ALGD};

        if (depth < need) begin
            r.error_code = E_UNDER;
        end else if (grow && depth >= STACK_DEPTH) begin
            r.error_code = E_OVER;
        end else begin
            case (f)
                F_PUSH: begin
                    push_cell(lit);
                    r.status = ST_PUSHED;
                end
                F_ADD:  begin b = pop_cell(); a = pop_cell(); push_cell(a + b); end
                F_SUB:  begin b = pop_cell(); a = pop_cell(); push_cell(a - b); end
                F_MUL:  begin b = pop_cell(); a = pop_cell(); push_cell(a * b); end
                F_DIV: begin
                    b = pop_cell(); a = pop_cell();
                    if (b == '0) r.error_code = E_DIVZ;
                    else push_cell(div_trunc(a, b));
                end
                F_PRT: begin
                    r.print_value = pop_cell();
                    r.print_valid = 1'b1;
                end
                F_DUP:  push_cell(stk[depth-1]);
                F_SWAP: begin b = pop_cell(); a = pop_cell(); push_cell(b); push_cell(a); end
                F_ROT: begin
                    c = pop_cell(); b = pop_cell(); a = pop_cell();
                    push_cell(b); push_cell(c); push_cell(a);
                end
                F_OVER: push_cell(stk[depth-2]);
                F_DROP: a = pop_cell();
                F_LT, F_LE, F_NE, F_EQ, F_GT, F_GE: begin
                    bit t;
                    b = pop_cell(); a = pop_cell();
                    case (f)
                        F_LT:    t = $signed(a) <  $signed(b);
                        F_LE:    t = $signed(a) <= $signed(b);
                        F_NE:    t = a != b;
                        F_EQ:    t = a == b;
                        F_GT:    t = $signed(a) >  $signed(b);
                        default: t = $signed(a) >= $signed(b);
                    endcase
                    push_cell({64{t}});
                end
                F_AND: begin b = pop_cell(); a = pop_cell(); push_cell(a & b); end
                F_OR:  begin b = pop_cell(); a = pop_cell(); push_cell(a | b); end
                F_XOR: begin b = pop_cell(); a = pop_cell(); push_cell(a ^ b); end
                F_INV: begin a = pop_cell(); push_cell(~a); end
                F_EMIT: begin
                    a = pop_cell();
                    r.print_value   = {56'd0, a[7:0]};
                    r.print_valid   = 1'b1;
                    r.print_is_char = 1'b1;
                end
                F_STO: begin
                    a = pop_cell(); b = pop_cell();
                    if (!cell_ok(a)) r.error_code = E_STO;
                    else for (int i = 0; i < CELL_B; i++) mem[int'(a) + i] = b[8*i +: 8];
                end
                F_FET: begin
                    a = pop_cell();
                    if (!cell_ok(a)) begin
                        r.error_code = E_FET;
                    end else begin
                        for (int i = 0; i < CELL_B; i++) b[8*i +: 8] = mem[int'(a) + i];
                        push_cell(b);
                    end
                end
                F_HERE: push_cell(64'(here_ptr));
                F_ALLT: begin
                    a = pop_cell();
                    if (a[63]) begin
                        m = -a;
                        if (m > 64'(here_ptr)) begin
                            here_ptr = 0;
                            r.error_code = E_ALLB;
                        end else begin
                            here_ptr -= int'(m);
                        end
                    end else if (a > 64'(DATA_BYTES - here_ptr)) begin
                        r.error_code = E_FULL;
                    end else begin
                        for (int i = 0; i < int'(a); i++) mem[here_ptr + i] = 8'd0;
                        here_ptr += int'(a);
                    end
                end
                F_ALGN: begin
                    n = next_aligned();
                    if (n > DATA_BYTES) begin
                        r.error_code = E_FULL;
                    end else begin
                        for (int i = here_ptr; i < n; i++) mem[i] = 8'd0;
                        here_ptr = n;
                    end
                end
                F_ALGD: push_cell(64'(next_aligned()));
                default: ;
            endcase
        end

        // any error empties the stack and drops the print
        if (r.error_code != E_NONE) begin
            r.status = ST_ERROR;
            depth = 0;
            r.print_valid = 1'b0;
            r.print_is_char = 1'b0;
            r.print_value = '0;
        end
        r.stack_depth = 7'(depth);
        r.top_value = depth != 0 ? stk[depth-1] : '0;
        return r;
    endfunction

    assign pending = exp_wr - exp_rd;

    always @(posedge aclk) begin
        smeu_res_t got, exp_r;
        if (!aresetn) begin
            depth = 0;
            here_ptr = 0;
            exp_wr = 0;
            exp_rd = 0;
            fail_count <= 0;
        end else begin
            // predict on request accept
            if (s_tvalid && s_tready) begin
                exp_mem[exp_wr % EXP_SLOTS] = execute(s_tdata[4:0], s_tdata[68:5]);
                exp_wr++;
            end

            // compare on result accept
            if (m_tvalid && m_tready) begin
                got.status        = m_tdata[1:0];
                got.error_code    = m_tdata[4:2];
                got.print_valid   = m_tdata[5];
                got.print_is_char = m_tdata[6];
                got.print_value   = m_tdata[70:7];
                got.stack_depth   = m_tdata[77:71];
                got.top_value     = m_tdata[141:78];
                if (exp_wr == exp_rd) begin
                    if (fail_count < 10)
                        $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = exp_mem[exp_rd % EXP_SLOTS];
                    exp_rd++;
                    if (got !== exp_r) begin
                        if (fail_count < 10)
                            $display("mismatch: exp st=%0d err=%0d pv=%0b pc=%0b pval=%h dep=%0d top=%h, got st=%0d err=%0d pv=%0b pc=%0b pval=%h dep=%0d top=%h",
                                exp_r.status, exp_r.error_code, exp_r.print_valid,
                                exp_r.print_is_char, exp_r.print_value, exp_r.stack_depth,
                                exp_r.top_value, got.status, got.error_code,
                                got.print_valid, got.print_is_char, got.print_value,
                                got.stack_depth, got.top_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### test/tb_stack_machine_execute_unit_core.sv
// ----------------------------------------------------------------------------
// tb_stack_machine_execute_unit_core: execute unit testbench
// Directed corner requests, then random well-formed word sequences mixed with
// noise, under bursty requests and a stalling receiver; the checker scores.
// ----------------------------------------------------------------------------
module tb_stack_machine_execute_unit_core;
    import smeu_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int N_ITEMS        = 850;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    int           fail_count;
    int           pending;
    int           sent = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stack_machine_execute_unit_core u_dut (.*);

    stack_machine_execute_unit_checker u_chk (.*);

    // receiver stall pattern: runs of free flow, random stalls and long holds
    always @(posedge aclk) begin
        int mode;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            mode = ($urandom_range(0, 63) + sent / 50) % 8;
            if (mode < 4)      m_tready <= 1'b1;
            else if (mode < 7) m_tready <= 1'($urandom_range(0, 1));
            else               m_tready <= ($urandom_range(0, 15) == 0);
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [4:0] f, input logic [63:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tdata  <= {3'b000, v, f};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_cell();
        case ($urandom_range(0, 7))
            0:       return 64'h8000_0000_0000_0000;
            1:       return 64'h7FFF_FFFF_FFFF_FFFF;
            2:       return '1;
            3:       return '0;
            4, 5:    return 64'($signed($urandom_range(0, 40)) - 20);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // unary, binary or ternary word with fresh operands
    task automatic run_arith();
        logic [4:0] f;
        f = 5'($urandom_range(F_ADD, F_INV));
        if (f == F_PRT || f == F_DUP || f == F_DROP) f = F_INV;
        if (f == F_ROT) send_req(F_PUSH, rand_cell());
        send_req(F_PUSH, rand_cell());
        send_req(F_PUSH, ($urandom_range(0, 5) == 0) ? 64'd0 : rand_cell());
        send_req(f, rand_cell());
        send_req(($urandom_range(0, 1) != 0) ? F_PRT : F_EMIT, rand_cell());
    endtask

    // cell store and read back inside or just past the data space
    task automatic run_memory();
        logic [63:0] addr;
        addr = 64'($urandom_range(0, 70));
        send_req(F_PUSH, rand_cell());
        send_req(F_PUSH, addr);
        send_req(F_STO, '0);
        send_req(F_PUSH, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 70)) : addr);
        send_req(F_FET, '0);
        send_req(F_PRT, '0);
    endtask

    task automatic run_space();
        case ($urandom_range(0, 5))
            0: begin send_req(F_PUSH, 64'($urandom_range(0, 40))); send_req(F_ALLT, '0); end
            1: begin send_req(F_PUSH, -64'($urandom_range(1, 90))); send_req(F_ALLT, '0); end
            2: send_req(F_ALGN, '0);
            3: send_req(F_ALGD, '0);
            4: send_req(F_HERE, '0);
            default: begin send_req(F_PUSH, 64'd72); send_req(F_ALLT, '0); end
        endcase
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: underflow on empty stack, extremes, data space corners, undefined codes
        send_req(F_EMIT, '0);
        send_req(F_PUSH, 64'h8000_0000_0000_0000);
        send_req(F_PUSH, '1);
        send_req(F_DIV, '0);              // most negative / -1 wraps
        send_req(F_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_req(F_PUSH, '0);
        send_req(F_DIV, '0);              // divide by zero
        send_req(F_PUSH, 64'd16);
        send_req(F_ALLT, '0);
        send_req(F_PUSH, 64'h0123_4567_89AB_CDEF);
        send_req(F_PUSH, 64'd8);
        send_req(F_STO, '0);              // last whole cell
        send_req(F_PUSH, 64'd9);
        send_req(F_FET, '0);              // cell runs past here
        send_req(F_PUSH, 64'd3);
        send_req(F_ALLT, '0);
        send_req(F_ALGN, '0);
        send_req(F_PUSH, -64'd100);
        send_req(F_ALLT, '0);             // shrink below zero
        send_req(F_PUSH, 64'd9000);
        send_req(F_ALLT, '0);             // data space full
        send_req(5'd28, '0);
        send_req(5'd31, '1);

        // fill the stack past its depth
        send_req(F_PUSH, 64'd1);
        for (int i = 0; i < 64; i++) send_req(i[0] ? F_OVER : F_DUP, '0);
        send_req(F_DROP, '0);
        send_req(F_HERE, '0);
        send_req(F_ALGD, '0);

        // hold until everything has drained
        drain();

        send_req(F_PUSH, 64'd64);
        send_req(F_ALLT, '0);

        // random part
        while (sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: run_arith();
                3, 4:    run_memory();
                5:       run_space();
                6: begin
                    send_req(F_PUSH, rand_cell());
                    send_req(F_PUSH, rand_cell());
                    send_req(F_PUSH, rand_cell());
                    send_req(5'($urandom_range(F_DUP, F_DROP)), '0);
                end
                7: send_req(5'($urandom_range(0, 31)), rand_cell());
                8: send_req(F_PUSH, rand_cell());
                default: begin
                    if ($urandom_range(0, 1) != 0) begin
                        send_req(F_PUSH, 64'(8192));
                        send_req(F_ALLT, '0);
                    end else begin
                        send_req(F_DROP, '0);
                    end
                end
            endcase
            if ($urandom_range(0, 120) == 0) drain();
        end

        drain();
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### stack_machine_execute_unit_core.f
src/smeu_pkg.sv
src/smeu_front.sv
src/smeu_div.sv
src/smeu_back.sv
src/stack_machine_execute_unit_core.sv
test/stack_machine_execute_unit_checker.sv
test/tb_stack_machine_execute_unit_core.sv
